// ----- hw/rtl/mabls_pkg.sv -----
// Shared types, constants and width helpers for the ADC button level scanner.
package mabls_pkg;

    // Default values of the top-level parameters
    localparam int CHANNELS_DEF = 8;
    localparam int SAMPLES_DEF  = 4;
    localparam int ADC_BITS_DEF = 12;

    // Fixed field widths
    localparam int CH_W    = 3;
    localparam int SMP_W   = 12;
    localparam int THR_W   = 12;
    localparam int STATE_W = 2;
    localparam int EVT_W   = 8;
    localparam int REG_IDX_W = 2;

    // Request function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_THR_SKIP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THR_PLAY = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THR_LOCK = 2'd2;

    localparam logic [THR_W-1:0] THR_SKIP_RST = 12'd1024;
    localparam logic [THR_W-1:0] THR_PLAY_RST = 12'd2048;
    localparam logic [THR_W-1:0] THR_LOCK_RST = 12'd3072;

    // Button classes
    localparam logic [STATE_W-1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [STATE_W-1:0] CLS_SKIP    = 2'd1;
    localparam logic [STATE_W-1:0] CLS_PLAY    = 2'd2;
    localparam logic [STATE_W-1:0] CLS_LOCK    = 2'd3;

    localparam logic [EVT_W-1:0] EVT_MAX = 8'hFF;

    // Result queue depth; also bounds the groups in flight
    localparam int QUEUE_DEPTH = 4;

    // Per-channel state entry
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [EVT_W-1:0]   count;
    } state_word_t;

    // One result item
    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [STATE_W-1:0] btn_class;
        logic               changed;
        logic [EVT_W-1:0]   pending_events;
    } result_t;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Accumulator width that holds SAMPLES full-scale samples
    function automatic int sum_width(input int samples, input int adc_bits);
        return $clog2(samples * ((1 << adc_bits) - 1) + 1);
    endfunction

endpackage

// ----- hw/rtl/mabls_in_if.sv -----
// Request channel: ADC samples and clear commands.
interface mabls_in_if;
    import mabls_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [CH_W-1:0]    channel;
    logic [SMP_W-1:0]   sample;

    modport source (output valid, output func, output channel, output sample, input ready);
    modport sink   (input valid, input func, input channel, input sample, output ready);
endinterface

// ----- hw/rtl/mabls_out_if.sv -----
// Result channel: classified button state per completed sample group.
interface mabls_out_if;
    import mabls_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_channel;
    logic [STATE_W-1:0] btn_class;
    logic               changed;
    logic [EVT_W-1:0]   pending_events;

    modport source (output valid, output out_channel, output btn_class, output changed,
                    output pending_events, input ready);
    modport sink   (input valid, input out_channel, input btn_class, input changed,
                    input pending_events, output ready);
endinterface

// ----- hw/rtl/multiplexed_adc_button_level_scanner_core.sv -----
// Top level of the multiplexed ADC button level scanner.
//
//  port        dir   handshake      carries
//  samples     sink  valid/ready    func, channel, sample
//  results     src   valid/ready    out_channel, btn_class, changed, pending_events
//  cfg_*       in    cfg_we only    threshold register writes (index, data)
//
// One request per cycle is taken while samples.ready is high; a group completes on its
// SAMPLES-th sample and its result then goes through read/multiply, classify/write-back and queue.
// Throughput is one request per cycle while samples.ready is high: the state memory has
// one read and one write port, so a lookup and a write-back share a cycle.
// samples.ready drops once four results are in flight or queued; requests are
// taken regardless of the results side as long as the queue has room.
// Reset clears thresholds to their defaults, the accumulator, and the valid bits of the
// state memory, so every channel reads unknown with a zero count. No clearing pass.
module multiplexed_adc_button_level_scanner_core
    import mabls_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int SAMPLES  = SAMPLES_DEF,
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    mabls_in_if.sink             samples,
    mabls_out_if.source          results,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data
);

    localparam int IDX_W   = idx_width(CHANNELS);
    localparam int SUM_W   = sum_width(SAMPLES, ADC_BITS);
    // Mean by reciprocal: floor(sum / SAMPLES) == (sum * RECIP) >> SHIFT for every sum
    // that fits SUM_W bits, with RECIP rounded up.
    localparam int SHIFT   = SUM_W + $clog2(SAMPLES);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) + SAMPLES - 1) / SAMPLES;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic [CH_W+1:0]  CH_LIMIT = (CH_W + 2)'(CHANNELS);

    // Threshold registers
    logic [THR_W-1:0] thr_skip_reg, thr_skip_next;
    logic [THR_W-1:0] thr_play_reg, thr_play_next;
    logic [THR_W-1:0] thr_lock_reg, thr_lock_next;

    always_comb
    begin
        thr_skip_next = thr_skip_reg;
        thr_play_next = thr_play_reg;
        thr_lock_next = thr_lock_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THR_SKIP: thr_skip_next = cfg_data;
                REG_THR_PLAY: thr_play_next = cfg_data;
                REG_THR_LOCK: thr_lock_next = cfg_data;
                default:      ;   // unmapped index: write dropped
            endcase
        end
    end

    // Request decode
    logic in_accept, is_clear, in_range, smp_accept, issue;
    logic grp_done;
    logic [SUM_W-1:0] grp_total;

    assign in_accept  = samples.valid && samples.ready;
    assign is_clear   = in_accept && (samples.func == FUNC_CLEAR);
    assign in_range   = ({2'b00, samples.channel} < CH_LIMIT);   // out-of-range: dropped
    assign smp_accept = in_accept && (samples.func == FUNC_SAMPLE) && in_range;
    assign issue      = smp_accept && grp_done;                   // group completes

    mabls_accum #(
        .SAMPLES  (SAMPLES),
        .ADC_BITS (ADC_BITS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (smp_accept),
        .sample (samples.sample),
        .done   (grp_done),
        .total  (grp_total)
    );

    // Stage 1: memory read in flight, reciprocal multiply
    logic             s1_v_reg;
    logic [SUM_W-1:0] s1_total_reg;
    logic [CH_W-1:0]  s1_ch_reg;

    // Stage 2: classify, update counter, write back, push result
    logic              s2_v_reg;
    logic [PROD_W-1:0] s2_prod_reg, s2_prod_next;
    logic [CH_W-1:0]   s2_ch_reg;
    logic              s2_clr_reg;   // a clear was taken after this group: count stores as zero

    assign s2_prod_next = PROD_W'(s1_total_reg) * PROD_W'(RECIP_V);

    state_word_t      cur_word, wr_word;
    logic [THR_W-1:0] mean;
    logic [STATE_W-1:0] cls;
    logic             chg;
    logic [EVT_W-1:0] new_count;
    result_t          res;

    assign mean = THR_W'(s2_prod_reg[SHIFT +: ADC_BITS]);

    // Checked in order lock, play, skip
    always_comb
    begin
        priority if (mean >= thr_lock_reg)
            cls = CLS_LOCK;
        else if (mean >= thr_play_reg)
            cls = CLS_PLAY;
        else if (mean >= thr_skip_reg)
            cls = CLS_SKIP;
        else
            cls = CLS_UNKNOWN;
    end

    assign chg       = (cls != cur_word.state);
    assign new_count = (chg && (cur_word.count != EVT_MAX)) ? cur_word.count + 1'b1
                                                            : cur_word.count;

    assign wr_word.state = cls;
    assign wr_word.count = s2_clr_reg ? '0 : new_count;

    assign res.out_channel    = s2_ch_reg;
    assign res.btn_class      = cls;
    assign res.changed        = chg;
    assign res.pending_events = new_count;

    mabls_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (IDX_W'(samples.channel)),
        .s1_idx  (IDX_W'(s1_ch_reg)),
        .wr_en   (s2_v_reg),
        .wr_idx  (IDX_W'(s2_ch_reg)),
        .wr_word (wr_word),
        .clear   (is_clear),
        .s2_word (cur_word)
    );

    mabls_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_v_reg),
        .push_data (res),
        .results   (results)
    );

    // Groups in stage 1, stage 2 or the queue
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             pop;

    assign pop            = results.valid && results.ready;
    assign occ_next       = occ_reg + OCC_W'(issue) - OCC_W'(pop);
    assign samples.ready  = (occ_reg < OCC_FULL);

    always_ff @(posedge clk)
    begin
        s1_total_reg <= grp_total;
        s1_ch_reg    <= samples.channel;
        s2_prod_reg  <= s2_prod_next;
        s2_ch_reg    <= s1_ch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_skip_reg <= THR_SKIP_RST;
            thr_play_reg <= THR_PLAY_RST;
            thr_lock_reg <= THR_LOCK_RST;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s2_clr_reg   <= 1'b0;
            occ_reg      <= '0;
        end
        else
        begin
            thr_skip_reg <= thr_skip_next;
            thr_play_reg <= thr_play_next;
            thr_lock_reg <= thr_lock_next;
            s1_v_reg     <= issue;
            s2_v_reg     <= s1_v_reg;
            s2_clr_reg   <= is_clear;
            occ_reg      <= occ_next;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("more groups in flight than the result queue holds");

    a_issue_flows: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_v_reg ##1 s2_v_reg)
        else $error("completed group lost in the pipeline");

    a_result_counted: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (occ_reg != '0))
        else $error("result offered with no group accounted for");

endmodule

// ----- hw/rtl/mabls_accum.sv -----
// Running sample accumulator: gathers one group of SAMPLES samples.
module mabls_accum
    import mabls_pkg::*;
#(
    parameter int SAMPLES  = SAMPLES_DEF,
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   take,
    input  logic [SMP_W-1:0]                       sample,
    output logic                                   done,
    output logic [sum_width(SAMPLES, ADC_BITS)-1:0] total
);

    localparam int SUM_W = sum_width(SAMPLES, ADC_BITS);
    localparam int CNT_W = idx_width(SAMPLES);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign total = sum_reg + SUM_W'(sample[ADC_BITS-1:0]);
    assign done  = (cnt_reg == LAST);

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            if (done)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = total;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/mabls_store.sv -----
// Per-channel state memory with valid bits and read-after-write forwarding.
module mabls_store
    import mabls_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [idx_width(CHANNELS)-1:0] rd_idx,   // read issued at request accept
    input  logic [idx_width(CHANNELS)-1:0] s1_idx,   // entry of the group in stage 1
    input  logic                           wr_en,
    input  logic [idx_width(CHANNELS)-1:0] wr_idx,
    input  state_word_t                    wr_word,
    input  logic                           clear,
    output state_word_t                    s2_word   // latest entry for the group in stage 2
);

    state_word_t mem [CHANNELS];
    state_word_t mem_q_reg;
    state_word_t fwd_word_reg;
    state_word_t s1_word;
    state_word_t s2_word_reg, s2_word_next;
    logic        fwd_hit_reg, fwd_hit_next;
    logic        sv_reg, cv_reg;
    logic [CHANNELS-1:0] state_valid_reg, state_valid_next;
    logic [CHANNELS-1:0] count_valid_reg, count_valid_next;

    // Entry never written reads unknown/zero; count invalidated by clear reads zero
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            s1_word = fwd_word_reg;
        end
        else
        begin
            s1_word.state = sv_reg ? mem_q_reg.state : CLS_UNKNOWN;
            s1_word.count = cv_reg ? mem_q_reg.count : '0;
        end
    end

    assign fwd_hit_next = wr_en && (wr_idx == rd_idx);
    assign s2_word_next = (wr_en && (wr_idx == s1_idx)) ? wr_word : s1_word;
    assign s2_word      = s2_word_reg;

    always_comb
    begin
        state_valid_next = state_valid_reg;
        count_valid_next = count_valid_reg;
        if (wr_en)
        begin
            state_valid_next[wr_idx] = 1'b1;
            count_valid_next[wr_idx] = 1'b1;
        end
        if (clear)
        begin
            count_valid_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg    <= mem[rd_idx];
        fwd_word_reg <= wr_word;
        s2_word_reg  <= s2_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_valid_reg <= '0;
            count_valid_reg <= '0;
            fwd_hit_reg     <= 1'b0;
            sv_reg          <= 1'b0;
            cv_reg          <= 1'b0;
        end
        else
        begin
            state_valid_reg <= state_valid_next;
            count_valid_reg <= count_valid_next;
            fwd_hit_reg     <= fwd_hit_next;
            sv_reg          <= state_valid_reg[rd_idx];
            cv_reg          <= count_valid_reg[rd_idx];
        end
    end

    a_clear_wipes: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (count_valid_reg == '0))
        else $error("count valid bits survive a clear");

endmodule

// ----- hw/rtl/mabls_outq.sv -----
// Result queue: small register FIFO that decouples the result channel.
module mabls_outq
    import mabls_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  result_t             push_data,
    mabls_out_if.source         results
);

    localparam int PTR_W = idx_width(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    result_t          q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    result_t          head;

    assign head                   = q_reg[rd_ptr_reg];
    assign results.valid          = (cnt_reg != '0);
    assign results.out_channel    = head.out_channel;
    assign results.btn_class      = head.btn_class;
    assign results.changed        = head.changed;
    assign results.pending_events = head.pending_events;

    assign pop         = results.valid && results.ready;
    assign wr_ptr_next = push ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
